@@ hw/rtl/aes_gcm_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-GCM shared definitions
// Types, codes, the AES S-box and the AES round and key-schedule helpers.
// ----------------------------------------------------------------------------
package aes_gcm_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_AAD   = 2'd1,
    CMD_PAY   = 2'd2,
    CMD_FIN   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0,
    KIND_PAY = 2'd1,
    KIND_TAG = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_LENGTH   = 2'd2,
    ST_ORDER    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_AAD     = 3'd1,
    PH_AAD_END = 3'd2,
    PH_PAY     = 3'd3,
    PH_PAY_END = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_AAD   = 3'd1,
    OP_PAY   = 3'd2,
    OP_FIN   = 3'd3,
    OP_REPLY = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    BE_IDLE  = 3'd0,
    BE_KLOAD = 3'd1,
    BE_KLD2  = 3'd2,
    BE_KEXP  = 3'd3,
    BE_ENC   = 3'd4,
    BE_GHASH = 3'd5,
    BE_RESP  = 3'd6
  } be_state_e;

  typedef enum logic [1:0] {
    ENC_H   = 2'd0,
    ENC_J0  = 2'd1,
    ENC_CTR = 2'd2
  } enc_sel_e;

  localparam logic [2:0] CFG_KEY0    = 3'd0;
  localparam logic [2:0] CFG_KEY1    = 3'd1;
  localparam logic [2:0] CFG_KEY2    = 3'd2;
  localparam logic [2:0] CFG_KEY3    = 3'd3;
  localparam logic [2:0] CFG_NONCE_U = 3'd4;
  localparam logic [2:0] CFG_NONCE_L = 3'd5;
  localparam logic [2:0] CFG_DECRYPT = 3'd6;

  localparam logic [61:0] AAD_LIMIT = 62'h1FFF_FFFF_FFFF_FFFF;
  localparam logic [36:0] PAY_LIMIT = 37'h0F_FFFF_FFE0;
  localparam logic [3:0]  LAST_ROUND = 4'd14;
  localparam logic [7:0]  GF_POLY   = 8'he1;
  localparam logic [7:0]  AES_POLY  = 8'h1b;

  // one queued operation between the front and the back
  typedef struct packed {
    op_e          op;
    logic [127:0] data;
    logic [127:0] aux;
    logic [31:0]  ctr;
    kind_e        kind;
    status_e      status;
  } op_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? AES_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // SubBytes, ShiftRows and, except in the last round, MixColumns
  function automatic logic [127:0] aes_round(input logic [127:0] st, input logic last);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int j = 0; j < 16; j++) begin
      t[j] = SBOX[st[127 - 8 * ((j + 4 * (j & 3)) & 15) -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      a0  = t[4 * c];
      a1  = t[4 * c + 1];
      a2  = t[4 * c + 2];
      a3  = t[4 * c + 3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        r[127 - 32 * c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127 - 32 * c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                 a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
      end
    end
    aes_round = r;
  endfunction

endpackage

@@ hw/rtl/aes_gcm_if.sv @@
// ----------------------------------------------------------------------------
// AES-GCM stream channels
// Request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface aes_gcm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic [4:0]  valid_bytes;

  modport source (output valid, command, data_high, data_low, valid_bytes, input ready);
  modport sink (input valid, command, data_high, data_low, valid_bytes, output ready);
endinterface

interface aes_gcm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic [1:0]  result_kind;
  logic [1:0]  status;

  modport source (output valid, result_high, result_low, result_kind, status, input ready);
  modport sink (input valid, result_high, result_low, result_kind, status, output ready);
endinterface

@@ hw/rtl/aes_gcm_front.sv @@
// ----------------------------------------------------------------------------
// AES-GCM front end
// Checks order and length limits, tracks counters and queues operations.
// ----------------------------------------------------------------------------
module aes_gcm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  aes_gcm_in_if.sink         in_i,
  input  logic               full_i,
  output logic               push_o,
  output aes_gcm_pkg::op_t   op_o
);
  import aes_gcm_pkg::*;

  phase_e       phase_q, phase_d;
  logic [60:0]  aad_q, aad_d;
  logic [35:0]  pay_q, pay_d;
  logic [31:0]  ctr_q, ctr_d;
  logic [4:0]   n;
  logic [127:0] mask;
  logic [127:0] blk;
  logic [61:0]  aad_sum;
  logic [36:0]  pay_sum;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    n       = (in_i.valid_bytes > 5'd16) ? 5'd16 : in_i.valid_bytes;
    mask    = ~({128{1'b1}} >> {n, 3'b000});
    blk     = {in_i.data_high, in_i.data_low};
    aad_sum = {1'b0, aad_q} + 62'(n);
    pay_sum = {1'b0, pay_q} + 37'(n);
    phase_d = phase_q;
    aad_d   = aad_q;
    pay_d   = pay_q;
    ctr_d   = ctr_q;
    op_o.op     = OP_REPLY;
    op_o.data   = blk & mask;
    op_o.aux    = mask;
    op_o.ctr    = ctr_q;
    op_o.kind   = KIND_ACK;
    op_o.status = ST_OK;
    case (cmd_e'(in_i.command))
      CMD_START: begin
        op_o.op = OP_START;
        phase_d = PH_AAD;
        aad_d   = '0;
        pay_d   = '0;
        ctr_d   = 32'd1;
      end
      CMD_AAD: begin
        if (phase_q != PH_AAD) begin
          op_o.status = ST_ORDER;
        end else if (aad_sum > AAD_LIMIT) begin
          op_o.status = ST_LENGTH;
        end else begin
          if (n != 5'd0) begin
            op_o.op = OP_AAD;
          end
          aad_d = aad_sum[60:0];
          if (n < 5'd16) begin
            phase_d = PH_AAD_END;
          end
        end
      end
      CMD_PAY: begin
        if (phase_q != PH_AAD && phase_q != PH_AAD_END && phase_q != PH_PAY) begin
          op_o.status = ST_ORDER;
        end else if (pay_sum > PAY_LIMIT) begin
          op_o.status = ST_LENGTH;
        end else begin
          op_o.kind = KIND_PAY;
          if (n != 5'd0) begin
            op_o.op  = OP_PAY;
            ctr_d    = ctr_q + 32'd1;
            op_o.ctr = ctr_d;
          end
          pay_d   = pay_sum[35:0];
          phase_d = (n < 5'd16) ? PH_PAY_END : PH_PAY;
        end
      end
      CMD_FIN: begin
        if (phase_q == PH_IDLE) begin
          op_o.status = ST_ORDER;
        end else begin
          op_o.op   = OP_FIN;
          op_o.data = blk;
          op_o.aux  = {aad_q, 3'b000, 25'd0, pay_q, 3'b000};
          phase_d   = PH_IDLE;
        end
      end
      default: begin
        op_o.status = ST_ORDER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      aad_q   <= '0;
      pay_q   <= '0;
      ctr_q   <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      aad_q   <= aad_d;
      pay_q   <= pay_d;
      ctr_q   <= ctr_d;
    end
  end

endmodule

@@ hw/rtl/aes_gcm_queue.sv @@
// ----------------------------------------------------------------------------
// AES-GCM operation queue
// Two-entry FIFO between the front end and the engine.
// ----------------------------------------------------------------------------
module aes_gcm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  aes_gcm_pkg::op_t data_i,
  input  logic             pop_i,
  output aes_gcm_pkg::op_t data_o,
  output logic             full_o,
  output logic             empty_o
);
  import aes_gcm_pkg::*;

  op_t        mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

@@ hw/rtl/aes_gcm_back.sv @@
// ----------------------------------------------------------------------------
// AES-GCM engine
// Key expansion, shared AES round unit, byte-serial GHASH and result register.
// ----------------------------------------------------------------------------
module aes_gcm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  aes_gcm_pkg::op_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  logic [255:0]     key_i,
  input  logic [95:0]      nonce_i,
  input  logic             decrypt_i,
  aes_gcm_out_if.source    out_o
);
  import aes_gcm_pkg::*;

  be_state_e    state_q, state_d;
  op_t          cur_q, cur_d;
  logic [127:0] rk_q [15];
  logic         rk_we;
  logic [3:0]   rk_wa;
  logic [127:0] rk_wd;
  logic [255:0] win_q, win_d;
  logic [7:0]   rc_q, rc_d;
  logic [3:0]   kcnt_q, kcnt_d;
  logic [3:0]   rnd_q, rnd_d;
  logic [127:0] st_q, st_d;
  enc_sel_e     sel_q, sel_d;
  logic [127:0] hsub_q, hsub_d, tmask_q, tmask_d, acc_q, acc_d;
  logic [127:0] z_q, z_d, v_q, v_d, x_q, x_d;
  logic [3:0]   gcnt_q, gcnt_d;
  logic [127:0] res_q, res_d;
  kind_e        rkind_q, rkind_d;
  status_e      rstat_q, rstat_d;
  logic         out_valid_q, out_valid_d;
  logic [127:0] out_data_q, out_data_d;
  kind_e        out_kind_q, out_kind_d;
  status_e      out_stat_q, out_stat_d;
  logic         out_load;

  assign out_o.valid       = out_valid_q;
  assign out_o.result_high = out_data_q[127:64];
  assign out_o.result_low  = out_data_q[63:0];
  assign out_o.result_kind = out_kind_q;
  assign out_o.status      = out_stat_q;

  always_comb begin
    logic [31:0]  tw, n0, n1, n2, n3;
    logic [127:0] rnd_out, blk, tag, gz, gv, gx;
    state_d = state_q;
    cur_d   = cur_q;
    win_d   = win_q;
    rc_d    = rc_q;
    kcnt_d  = kcnt_q;
    rnd_d   = rnd_q;
    st_d    = st_q;
    sel_d   = sel_q;
    hsub_d  = hsub_q;
    tmask_d = tmask_q;
    acc_d   = acc_q;
    z_d     = z_q;
    v_d     = v_q;
    x_d     = x_q;
    gcnt_d  = gcnt_q;
    res_d   = res_q;
    rkind_d = rkind_q;
    rstat_d = rstat_q;
    pop_o   = 1'b0;
    rk_we   = 1'b0;
    rk_wa   = kcnt_q;
    rk_wd   = '0;
    out_load = 1'b0;

    // next round key from the sliding eight-word window
    tw = (kcnt_q[0] == 1'b0)
         ? sub_word({win_q[23:0], win_q[31:24]}) ^ {rc_q, 24'd0}
         : sub_word(win_q[31:0]);
    n0 = win_q[255:224] ^ tw;
    n1 = win_q[223:192] ^ n0;
    n2 = win_q[191:160] ^ n1;
    n3 = win_q[159:128] ^ n2;

    rnd_out = aes_round(st_q, rnd_q == LAST_ROUND) ^ rk_q[rnd_q];

    // eight multiplier bits per cycle, most significant first
    gz = z_q;
    gv = v_q;
    gx = x_q;
    for (int k = 0; k < 8; k++) begin
      if (gx[127]) begin
        gz = gz ^ gv;
      end
      gv = {GF_POLY & {8{gv[0]}}, 120'd0} ^ {1'b0, gv[127:1]};
      gx = {gx[126:0], 1'b0};
    end

    blk = '0;
    tag = gz ^ tmask_q;

    case (state_q)
      BE_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cur_d   = head_i;
          res_d   = '0;
          rkind_d = head_i.kind;
          rstat_d = head_i.status;
          z_d     = '0;
          v_d     = hsub_q;
          gcnt_d  = '0;
          case (head_i.op)
            OP_START: state_d = BE_KLOAD;
            OP_AAD: begin
              x_d     = acc_q ^ head_i.data;
              state_d = BE_GHASH;
            end
            OP_PAY: begin
              st_d    = {nonce_i, head_i.ctr} ^ rk_q[0];
              rnd_d   = 4'd1;
              sel_d   = ENC_CTR;
              state_d = BE_ENC;
            end
            OP_FIN: begin
              x_d     = acc_q ^ head_i.aux;
              state_d = BE_GHASH;
            end
            default: state_d = BE_RESP;
          endcase
        end
      end
      BE_KLOAD: begin
        win_d   = key_i;
        rk_we   = 1'b1;
        rk_wa   = 4'd0;
        rk_wd   = key_i[255:128];
        rc_d    = 8'h01;
        state_d = BE_KLD2;
      end
      BE_KLD2: begin
        rk_we   = 1'b1;
        rk_wa   = 4'd1;
        rk_wd   = win_q[127:0];
        kcnt_d  = 4'd2;
        state_d = BE_KEXP;
      end
      BE_KEXP: begin
        rk_we  = 1'b1;
        rk_wd  = {n0, n1, n2, n3};
        win_d  = {win_q[127:0], n0, n1, n2, n3};
        kcnt_d = kcnt_q + 4'd1;
        if (kcnt_q[0] == 1'b0) begin
          rc_d = xtime(rc_q);
        end
        if (kcnt_q == LAST_ROUND) begin
          st_d    = rk_q[0];
          rnd_d   = 4'd1;
          sel_d   = ENC_H;
          state_d = BE_ENC;
        end
      end
      BE_ENC: begin
        st_d  = rnd_out;
        rnd_d = rnd_q + 4'd1;
        if (rnd_q == LAST_ROUND) begin
          case (sel_q)
            ENC_H: begin
              hsub_d = rnd_out;
              st_d   = {nonce_i, 32'd1} ^ rk_q[0];
              rnd_d  = 4'd1;
              sel_d  = ENC_J0;
            end
            ENC_J0: begin
              tmask_d = rnd_out;
              acc_d   = '0;
              state_d = BE_RESP;
            end
            default: begin
              res_d   = (cur_q.data ^ rnd_out) & cur_q.aux;
              blk     = decrypt_i ? cur_q.data : res_d;
              x_d     = acc_q ^ blk;
              state_d = BE_GHASH;
            end
          endcase
        end
      end
      BE_GHASH: begin
        z_d    = gz;
        v_d    = gv;
        x_d    = gx;
        gcnt_d = gcnt_q + 4'd1;
        if (gcnt_q == 4'd15) begin
          acc_d   = gz;
          state_d = BE_RESP;
          if (cur_q.op == OP_FIN) begin
            rkind_d = KIND_TAG;
            if (decrypt_i) begin
              res_d   = '0;
              rstat_d = (tag == cur_q.data) ? ST_OK : ST_MISMATCH;
            end else begin
              res_d = tag;
            end
          end
        end
      end
      BE_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = BE_IDLE;
        end
      end
      default: state_d = BE_IDLE;
    endcase

    out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_o.ready);
    out_data_d  = out_load ? res_q : out_data_q;
    out_kind_d  = out_load ? rkind_q : out_kind_q;
    out_stat_d  = out_load ? rstat_q : out_stat_q;
  end

  always_ff @(posedge clk_i) begin
    if (rk_we) begin
      rk_q[rk_wa] <= rk_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    win_q      <= win_d;
    rc_q       <= rc_d;
    st_q       <= st_d;
    z_q        <= z_d;
    v_q        <= v_d;
    x_q        <= x_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_IDLE;
      kcnt_q      <= '0;
      rnd_q       <= '0;
      sel_q       <= ENC_H;
      hsub_q      <= '0;
      tmask_q     <= '0;
      acc_q       <= '0;
      gcnt_q      <= '0;
      rkind_q     <= KIND_ACK;
      rstat_q     <= ST_OK;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_ACK;
      out_stat_q  <= ST_OK;
    end else begin
      state_q     <= state_d;
      kcnt_q      <= kcnt_d;
      rnd_q       <= rnd_d;
      sel_q       <= sel_d;
      hsub_q      <= hsub_d;
      tmask_q     <= tmask_d;
      acc_q       <= acc_d;
      gcnt_q      <= gcnt_d;
      rkind_q     <= rkind_d;
      rstat_q     <= rstat_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
      out_stat_q  <= out_stat_d;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i) else $error("pop from empty queue");

  a_kexp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_KEXP) |-> (kcnt_q >= 4'd2 && kcnt_q <= LAST_ROUND))
    else $error("key expansion index out of range");

  a_enc_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_ENC) |-> (rnd_q != 4'd0)) else $error("round zero in round loop");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending result overwritten");

endmodule

@@ hw/rtl/aes256_gcm_aead_engine.sv @@
// ----------------------------------------------------------------------------
// AES-256-GCM AEAD engine
// Top level: configuration registers, front end, queue and engine.
// ----------------------------------------------------------------------------
// Each request gives one result. Rejected requests, zero-length blocks and
// other replies go straight to the result stage; an AAD block takes a pass
// of the byte-serial GHASH multiplier; a payload block one pass of the
// 14-round AES unit at one round a cycle, then the GHASH fold; finish a
// GHASH pass over the length block; start runs the key expansion, then two
// AES passes for the hash subkey and the pre-counter block. The shared AES
// round unit and the GHASH multiplier serve one request at a time; a
// two-entry queue lets requests be taken while the engine works.
module aes256_gcm_aead_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  aes_gcm_in_if.sink    in_i,
  aes_gcm_out_if.source out_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i
);
  import aes_gcm_pkg::*;

  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_u_q;
  logic [31:0] nonce_l_q;
  logic        decrypt_q;
  logic        push, pop, full, empty;
  op_t         op_in, op_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q    <= '0;
      key1_q    <= '0;
      key2_q    <= '0;
      key3_q    <= '0;
      nonce_u_q <= '0;
      nonce_l_q <= '0;
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY0:    key0_q    <= cfg_data_i;
        CFG_KEY1:    key1_q    <= cfg_data_i;
        CFG_KEY2:    key2_q    <= cfg_data_i;
        CFG_KEY3:    key3_q    <= cfg_data_i;
        CFG_NONCE_U: nonce_u_q <= cfg_data_i;
        CFG_NONCE_L: nonce_l_q <= cfg_data_i[31:0];
        CFG_DECRYPT: decrypt_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  aes_gcm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .op_o   (op_in)
  );

  aes_gcm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .pop_i   (pop),
    .data_o  (op_head),
    .full_o  (full),
    .empty_o (empty)
  );

  aes_gcm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (op_head),
    .empty_i   (empty),
    .pop_o     (pop),
    .key_i     ({key0_q, key1_q, key2_q, key3_q}),
    .nonce_i   ({nonce_u_q, nonce_l_q}),
    .decrypt_i (decrypt_q),
    .out_o     (out_o)
  );

endmodule

@@ dv/aes256_gcm_aead_engine_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-256-GCM engine testbench
// Drives messages (start, AAD, payload, finish) through the request channel,
// predicts every result with an AES-256 / GHASH model of its own and checks
// each result in order. The run covers several keys, nonces and both modes.
// ----------------------------------------------------------------------------
module aes256_gcm_aead_engine_test;
  import aes_gcm_pkg::*;

  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nbytes;
  } request_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    kind_e       kind;
    status_e     status;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  aes_gcm_in_if  req_ch ();
  aes_gcm_out_if res_ch ();

  aes256_gcm_aead_engine i_dut (
    .clk_i, .rst_ni, .in_i(req_ch), .out_o(res_ch),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // model state
  logic [63:0]  key_w [4];
  logic [63:0]  nonce_hi;
  logic [31:0]  nonce_lo;
  logic         decrypting;
  logic [127:0] rkeys [15];
  logic [127:0] subkey_h, j0_mask, ghash_acc;
  logic [31:0]  ctr;
  logic [60:0]  aad_total;
  logic [35:0]  pay_total;
  phase_e       msg_phase;

  request_t pending_req [$];
  result_t  expected_res [$];
  int       errors = 0;
  int       send_idle = 0, recv_idle = 0;

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sb(input logic [7:0] x);
    return SBOX[x];
  endfunction

  function automatic void expand_key();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) w[i] = key_w[i / 2][63 - 32 * (i % 2) -: 32];
    for (int i = 8; i < 60; i++) begin
      t = w[i - 1];
      if (i % 8 == 0) begin
        t = {sb(t[23:16]) ^ rc, sb(t[15:8]), sb(t[7:0]), sb(t[31:24])};
        rc = gmul2(rc);
      end else if (i % 8 == 4) begin
        t = {sb(t[31:24]), sb(t[23:16]), sb(t[15:8]), sb(t[7:0])};
      end
      w[i] = w[i - 8] ^ t;
    end
    for (int r = 0; r < 15; r++) rkeys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] pt);
    logic [127:0] st, nx;
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, al;
    st = pt ^ rkeys[0];
    for (int r = 1; r <= 14; r++) begin
      for (int j = 0; j < 16; j++) t[j] = sb(st[127 - 8 * ((j + 4 * (j & 3)) & 15) -: 8]);
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        al = a0 ^ a1 ^ a2 ^ a3;
        if (r == 14) nx[127 - 32 * c -: 32] = {a0, a1, a2, a3};
        else nx[127 - 32 * c -: 32] = {a0 ^ al ^ gmul2(a0 ^ a1), a1 ^ al ^ gmul2(a1 ^ a2),
                                       a2 ^ al ^ gmul2(a2 ^ a3), a3 ^ al ^ gmul2(a3 ^ a0)};
      end
      st = nx ^ rkeys[r];
    end
    return st;
  endfunction

  function automatic void ghash_absorb(input logic [127:0] blk);
    logic [127:0] x, z, v;
    x = ghash_acc ^ blk;
    z = '0;
    v = subkey_h;
    for (int i = 0; i < 128; i++) begin
      if (x[127 - i]) z ^= v;
      v = {1'b0, v[127:1]} ^ (v[0] ? {8'he1, 120'b0} : 128'b0);
    end
    ghash_acc = z;
  endfunction

  function automatic result_t predict_result(input request_t rq);
    result_t      rs;
    logic [127:0] mask, blk, ks, ct, tag;
    int unsigned  n;
    n = (rq.nbytes > 16) ? 16 : rq.nbytes;
    mask = (n == 0) ? '0 : ~(128'h0) << (8 * (16 - n));
    blk = {rq.hi, rq.lo} & mask;
    rs = '{hi: '0, lo: '0, kind: KIND_ACK, status: ST_OK};
    case (rq.cmd)
      CMD_START: begin
        expand_key();
        subkey_h = encrypt_block('0);
        j0_mask = encrypt_block({nonce_hi, nonce_lo, 32'd1});
        ghash_acc = '0;
        ctr = 32'd1;
        aad_total = '0;
        pay_total = '0;
        msg_phase = PH_AAD;
      end
      CMD_AAD: begin
        if (msg_phase != PH_AAD) rs.status = ST_ORDER;
        else if ({1'b0, aad_total} + n > AAD_LIMIT) rs.status = ST_LENGTH;
        else begin
          if (n > 0) ghash_absorb(blk);
          aad_total += 61'(n);
          if (n < 16) msg_phase = PH_AAD_END;
        end
      end
      CMD_PAY: begin
        if (!(msg_phase inside {PH_AAD, PH_AAD_END, PH_PAY})) rs.status = ST_ORDER;
        else if ({1'b0, pay_total} + n > PAY_LIMIT) rs.status = ST_LENGTH;
        else begin
          rs.kind = KIND_PAY;
          if (n > 0) begin
            ctr += 32'd1;
            ks = encrypt_block({nonce_hi, nonce_lo, ctr});
            ct = ({rq.hi, rq.lo} ^ ks) & mask;
            {rs.hi, rs.lo} = ct;
            ghash_absorb(decrypting ? blk : ct);
          end
          pay_total += 36'(n);
          msg_phase = (n < 16) ? PH_PAY_END : PH_PAY;
        end
      end
      default: begin
        if (msg_phase == PH_IDLE) rs.status = ST_ORDER;
        else begin
          ghash_absorb({aad_total, 3'b0, 25'b0, pay_total, 3'b0});
          tag = ghash_acc ^ j0_mask;
          rs.kind = KIND_TAG;
          if (decrypting) rs.status = (tag == {rq.hi, rq.lo}) ? ST_OK : ST_MISMATCH;
          else {rs.hi, rs.lo} = tag;
          msg_phase = PH_IDLE;
        end
      end
    endcase
    return rs;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.command <= CMD_START;
      req_ch.data_high <= '0;
      req_ch.data_low <= '0;
      req_ch.valid_bytes <= '0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) expected_res.push_back(predict_result(
          '{cmd: cmd_e'(req_ch.command), hi: req_ch.data_high, lo: req_ch.data_low,
            nbytes: req_ch.valid_bytes}));
      if (pending_req.size() > 0 && $urandom_range(99) >= send_idle) begin
        req_ch.valid <= 1'b1;
        req_ch.command <= pending_req[0].cmd;
        req_ch.data_high <= pending_req[0].hi;
        req_ch.data_low <= pending_req[0].lo;
        req_ch.valid_bytes <= pending_req[0].nbytes;
        void'(pending_req.pop_front());
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_res.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h %h kind %0d status %0d", $time,
                   res_ch.result_high, res_ch.result_low, res_ch.result_kind, res_ch.status);
        end else begin
          if (res_ch.result_high !== expected_res[0].hi || res_ch.result_low !== expected_res[0].lo
              || res_ch.result_kind !== expected_res[0].kind
              || res_ch.status !== expected_res[0].status) begin
            errors++;
            $display("%0t: expected %h %h kind %0d status %0d, got %h %h kind %0d status %0d",
                     $time, expected_res[0].hi, expected_res[0].lo, expected_res[0].kind,
                     expected_res[0].status, res_ch.result_high, res_ch.result_low,
                     res_ch.result_kind, res_ch.status);
          end
          void'(expected_res.pop_front());
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_req(input cmd_e c, input logic [63:0] h, input logic [63:0] l,
                           input int nb);
    pending_req.push_back('{cmd: c, hi: h, lo: l, nbytes: 5'(nb)});
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: key_w[idx[1:0]] = val;
      CFG_NONCE_U: nonce_hi = val;
      CFG_NONCE_L: nonce_lo = val[31:0];
      default: decrypting = val[0];
    endcase
  endtask

  task automatic drain();
    while (pending_req.size() > 0 || req_ch.valid || expected_res.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // well-formed message with random content; in decrypt the tag is random, so almost always wrong
  task automatic queue_message(input int blocks_max);
    int na, np, nb;
    queue_req(CMD_START, rand64(), rand64(), $urandom_range(31));
    na = $urandom_range(3);
    for (int i = 0; i < na; i++) begin
      nb = (i == na - 1) ? $urandom_range(16) : 16;
      queue_req(CMD_AAD, rand64(), rand64(), nb);
    end
    np = $urandom_range(blocks_max);
    for (int i = 0; i < np; i++) begin
      nb = (i == np - 1) ? $urandom_range(20) : 16;
      queue_req(CMD_PAY, rand64(), rand64(), nb);
    end
    queue_req(CMD_FIN, rand64(), rand64(), $urandom_range(31));
  endtask

  task automatic queue_noise();
    queue_req(cmd_e'($urandom_range(3)), rand64(), rand64(), $urandom_range(31));
  endtask

  initial begin
    key_w = '{default: '0};
    nonce_hi = '0; nonce_lo = '0; decrypting = 0;
    rkeys = '{default: '0};
    subkey_h = '0; j0_mask = '0; ghash_acc = '0;
    ctr = '0; aad_total = '0; pay_total = '0; msg_phase = PH_IDLE;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: all-zero key and nonce first, then the extremes
    queue_req(CMD_AAD, '0, '0, 16);
    queue_req(CMD_FIN, '0, '0, 0);
    queue_req(CMD_START, '0, '0, 0);
    queue_req(CMD_FIN, '0, '0, 0);
    queue_req(CMD_START, '0, '0, 0);
    queue_req(CMD_AAD, '1, '1, 16);
    queue_req(CMD_AAD, '1, '1, 31);
    queue_req(CMD_AAD, '1, '1, 5);
    queue_req(CMD_AAD, '1, '1, 16);
    queue_req(CMD_PAY, '1, '1, 16);
    queue_req(CMD_PAY, '0, '0, 0);
    queue_req(CMD_PAY, '1, '1, 16);
    queue_req(CMD_FIN, '1, '1, 16);
    queue_req(CMD_FIN, '0, '0, 0);
    queue_req(CMD_START, '0, '0, 0);
    queue_req(CMD_AAD, 64'h0123456789abcdef, 64'hfedcba9876543210, 0);
    queue_req(CMD_PAY, '1, '0, 9);
    queue_req(CMD_START, '1, '1, 31);
    queue_req(CMD_PAY, 64'haaaa5555aaaa5555, 64'h5555aaaa5555aaaa, 17);
    queue_req(CMD_FIN, '0, '0, 0);
    drain();

    for (int p = 0; p < 9; p++) begin
      send_idle = (p < 3) ? 34 : (p < 6) ? 76 : 0;
      recv_idle = (p < 3) ? 76 : (p < 6) ? 34 : 0;
      for (int k = 0; k < 4; k++)
        write_reg(3'(k), (p == 0) ? '1 : (p == 1) ? '0 : rand64());
      write_reg(CFG_NONCE_U, (p == 0) ? '1 : (p == 1) ? '0 : rand64());
      write_reg(CFG_NONCE_L, (p == 0) ? 64'hffff_ffff : (p == 1) ? '0 : rand64());
      write_reg(CFG_DECRYPT, 64'(p % 2));
      while (pending_req.size() < 200) begin
        if ($urandom_range(9) < 8) queue_message(6);
        else queue_noise();
      end
      drain();
    end

    // decrypt with the correct tag: encrypt a message, then verify its tag
    write_reg(CFG_DECRYPT, 64'd0);
    queue_req(CMD_START, '0, '0, 0);
    queue_req(CMD_AAD, 64'h1111, 64'h2222, 7);
    queue_req(CMD_PAY, 64'h3333, 64'h4444, 16);
    queue_req(CMD_FIN, '0, '0, 0);
    drain();
    begin
      result_t tag_res;
      logic [127:0] ct_blk;
      write_reg(CFG_DECRYPT, 64'd1);
      // recompute the same message in encrypt terms to learn ciphertext and tag
      decrypting = 0;
      void'(predict_result('{cmd: CMD_START, hi: '0, lo: '0, nbytes: 0}));
      void'(predict_result('{cmd: CMD_AAD, hi: 64'h1111, lo: 64'h2222, nbytes: 7}));
      tag_res = predict_result('{cmd: CMD_PAY, hi: 64'h3333, lo: 64'h4444, nbytes: 16});
      ct_blk = {tag_res.hi, tag_res.lo};
      tag_res = predict_result('{cmd: CMD_FIN, hi: '0, lo: '0, nbytes: 0});
      decrypting = 1;
      queue_req(CMD_START, '0, '0, 0);
      queue_req(CMD_AAD, 64'h1111, 64'h2222, 7);
      queue_req(CMD_PAY, ct_blk[127:64], ct_blk[63:0], 16);
      queue_req(CMD_FIN, tag_res.hi, tag_res.lo, 0);
    end
    drain();
    if (errors == 0) $display("aes256_gcm_aead_engine_test OK");
    else $display("aes256_gcm_aead_engine_test NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("aes256_gcm_aead_engine_test NOT OK");
    $finish;
  end

endmodule
